[design/nfpp_pkg.sv]
// ---------------------------------------------------------------------------
// nfpp_pkg
// Shared constants and the coefficient table for the fixed-point Newton
// polynomial solver.
// ---------------------------------------------------------------------------
package nfpp_pkg;

  localparam int DEGREE_DEF    = 10;
  localparam int FRAC_BITS_DEF = 28;

  // coefficient index is four bits wide (degree at most 15)
  localparam int COEF_IDX_W = 4;
  localparam int COEF_CNT   = 16;

  localparam int TOL_W   = 29;
  localparam int LIMIT_W = 16;
  localparam int DATA_W  = 32;

  typedef logic [COEF_CNT-1:0][63:0] coef_tbl_t;

  // polynomial coefficients in units of 1e-4
  function automatic logic [12:0] coef_k(input int unsigned i);
    logic [12:0] k;
    case (i)
      0:       k = 13'd4982;
      1:       k = 13'd2103;
      2:       k = 13'd1270;
      3:       k = 13'd730;
      4:       k = 13'd418;
      5:       k = 13'd241;
      6:       k = 13'd132;
      7:       k = 13'd69;
      8:       k = 13'd35;
      9:       k = 13'd15;
      10:      k = 13'd5;
      default: k = 13'd0;
    endcase
    return k;
  endfunction

  // round(k * 2^frac / 10000), halves up; evaluated at elaboration
  function automatic coef_tbl_t coef_table(input int frac);
    coef_tbl_t t;
    for (int i = 0; i < COEF_CNT; i++) begin
      t[i] = ((64'(coef_k(i)) << frac) + 64'd5000) / 64'd10000;
    end
    return t;
  endfunction

endpackage

[design/newton_fixed_point_polynomial_unit.sv]
// ---------------------------------------------------------------------------
// newton_fixed_point_polynomial_unit
// Newton solver for the fixed point s = P(s) of a constant polynomial, in
// signed fixed point, with a shared multiplier and a bit-serial divider.
// ---------------------------------------------------------------------------
//  channel   ports                               handshake
//  -------   ---------------------------------   ---------------------------
//  input     in_start_value                      start & !busy
//  result    out_root_value                      out_valid, one cycle, no stall
//  config    psel penable pwrite paddr pwdata    APB, pready tied high
//            prdata pready
//
// One Newton pass runs Horner's rule on the one shared multiplier, three
// states (MULD, ADDD, ADDP) per step, then the restoring divider, one
// quotient bit per cycle, plus setup and update. A request takes from 1
// to iteration_limit+1 passes.
// busy stays high for the whole solve; the result strobe cannot be stalled.
// Reset restores the register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
module newton_fixed_point_polynomial_unit #(
  parameter int DEGREE    = nfpp_pkg::DEGREE_DEF,
  parameter int FRAC_BITS = nfpp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_start_value,
  output logic               out_valid,
  output logic signed [31:0] out_root_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW    = nfpp_pkg::COEF_IDX_W;
  localparam int AW    = (FRAC_BITS + 1 > 32) ? FRAC_BITS + 1 : 32;  // accumulators
  localparam int CW    = FRAC_BITS + 1;                              // coefficient
  localparam int PW    = 32 + AW;                                    // product
  localparam int NW    = AW + 1;                                     // numerator
  localparam int DW    = ((FRAC_BITS > 31) ? FRAC_BITS : 31) + 2;    // denominator
  localparam int QW    = NW + FRAC_BITS;                             // dividend/quotient
  localparam int CNT_W = $clog2(QW + 1);
  localparam int QMW   = 34;                                         // capped quotient
  localparam int SW    = 36;                                         // update sum

  localparam nfpp_pkg::coef_tbl_t COEF = nfpp_pkg::coef_table(FRAC_BITS);

  localparam logic signed [DW-1:0] ONE_Q   = DW'(1) << FRAC_BITS;
  localparam logic signed [63:0]   ONE_64  = 64'(1) << FRAC_BITS;
  localparam logic [QMW-1:0]       Q_CAP   = QMW'(1) << 33;
  localparam logic [31:0]          SAT_POS = 32'h7fff_ffff;
  localparam logic [31:0]          SAT_NEG = 32'h8000_0000;

  localparam logic REG_TOL   = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INIT = 4'd1;
  localparam logic [3:0] ST_MULD = 4'd2;
  localparam logic [3:0] ST_ADDD = 4'd3;
  localparam logic [3:0] ST_ADDP = 4'd4;
  localparam logic [3:0] ST_DSET = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_UPD  = 4'd7;
  localparam logic [3:0] ST_CHK  = 4'd8;

  // control
  logic [3:0]                     state_r, state_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [nfpp_pkg::TOL_W-1:0]     tol_r, tol_nxt;
  logic [nfpp_pkg::LIMIT_W-1:0]   limit_r, limit_nxt;

  // datapath
  logic signed [31:0]             est_r, est_nxt;
  logic signed [31:0]             next_r, next_nxt;
  logic [nfpp_pkg::LIMIT_W-1:0]   passes_r, passes_nxt;
  logic signed [AW-1:0]           poly_r, poly_nxt;
  logic signed [AW-1:0]           deriv_r, deriv_nxt;
  logic [IW-1:0]                  step_r, step_nxt;
  logic signed [PW-1:0]           prod_r, prod_nxt;
  logic [NW-1:0]                  nmag_r, nmag_nxt;
  logic [DW-1:0]                  dmag_r, dmag_nxt;
  logic                           neg_r, neg_nxt;
  logic [DW-1:0]                  rem_r, rem_nxt;
  logic [QW-1:0]                  dq_r, dq_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;

  logic                           cfg_wr;
  logic signed [63:0]             sv_w;
  logic signed [AW-1:0]           mul_op;
  logic [IW-1:0]                  coef_idx;
  logic signed [AW-1:0]           term;
  logic signed [PW-1:0]           prod_sh;
  logic signed [PW:0]             hsum;
  logic signed [31:0]             hsat;
  logic signed [NW-1:0]           num;
  logic signed [DW-1:0]           den;
  logic [DW:0]                    rem_sh;
  logic                           rem_ge;
  logic [QMW-1:0]                 qmag;
  logic signed [SW-1:0]           usum;
  logic signed [32:0]             diff;
  logic [32:0]                    diff_abs;
  logic                           solved;

  assign pready         = 1'b1;
  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_root_value = next_r;
  assign cfg_wr         = psel & penable & pwrite;
  assign prdata         = (paddr[2] == REG_LIMIT) ? 32'(limit_r) : 32'(tol_r);

  // shared multiplier operand and Horner adder
  assign mul_op   = (state_r == ST_ADDD) ? poly_r : deriv_r;
  assign coef_idx = step_r - IW'(1);
  assign term     = (state_r == ST_ADDD) ? poly_r : AW'($signed(COEF[coef_idx][CW-1:0]));
  assign prod_sh  = prod_r >>> FRAC_BITS;
  assign hsum     = (PW+1)'(prod_sh) + (PW+1)'(term);
  assign hsat     = (hsum[PW:31] != {(PW-30){hsum[PW]}}) ?
                    (hsum[PW] ? SAT_NEG : SAT_POS) : hsum[31:0];

  assign sv_w = 64'(in_start_value);
  assign num  = NW'(poly_r) - NW'(est_r);
  assign den  = ONE_Q - DW'(deriv_r);

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_r, dq_r[QW-1]};
  assign rem_ge = (rem_sh >= {1'b0, dmag_r});

  always_comb begin
    if (dmag_r == '0) begin
      qmag = (nmag_r == '0) ? '0 : Q_CAP;
    end else if (dq_r >= QW'(Q_CAP)) begin
      qmag = Q_CAP;
    end else begin
      qmag = dq_r[QMW-1:0];
    end
  end

  assign usum     = neg_r ? (SW'(est_r) - SW'(qmag)) : (SW'(est_r) + SW'(qmag));
  assign diff     = 33'(next_r) - 33'(est_r);
  assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
  assign solved   = (diff_abs <= 33'(tol_r)) || (passes_r == '0);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    tol_nxt       = tol_r;
    limit_nxt     = limit_r;
    est_nxt       = est_r;
    next_nxt      = next_r;
    passes_nxt    = passes_r;
    poly_nxt      = poly_r;
    deriv_nxt     = deriv_r;
    step_nxt      = step_r;
    prod_nxt      = prod_r;
    nmag_nxt      = nmag_r;
    dmag_nxt      = dmag_r;
    neg_nxt       = neg_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    cnt_nxt       = cnt_r;

    if (cfg_wr) begin
      if (paddr[2] == REG_TOL) begin
        tol_nxt = pwdata[nfpp_pkg::TOL_W-1:0];
      end else begin
        limit_nxt = pwdata[nfpp_pkg::LIMIT_W-1:0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // start outside [0, 1.0] falls back to zero
          est_nxt    = (sv_w < 0 || sv_w > ONE_64) ? '0 : in_start_value;
          passes_nxt = limit_r;
          state_nxt  = ST_INIT;
        end
      end
      ST_INIT: begin
        poly_nxt  = AW'($signed(COEF[IW'(DEGREE)][CW-1:0]));
        deriv_nxt = '0;
        step_nxt  = IW'(DEGREE);
        state_nxt = ST_MULD;
      end
      ST_MULD: begin
        prod_nxt  = PW'(est_r) * PW'(mul_op);
        state_nxt = ST_ADDD;
      end
      ST_ADDD: begin
        // derivative uses the old running value of P as its term
        deriv_nxt = AW'(hsat);
        prod_nxt  = PW'(est_r) * PW'(mul_op);
        state_nxt = ST_ADDP;
      end
      ST_ADDP: begin
        poly_nxt  = AW'(hsat);
        step_nxt  = coef_idx;
        state_nxt = (coef_idx == '0) ? ST_DSET : ST_MULD;
      end
      ST_DSET: begin
        nmag_nxt  = num[NW-1] ? NW'(-num) : NW'(num);
        dmag_nxt  = den[DW-1] ? DW'(-den) : DW'(den);
        neg_nxt   = num[NW-1] ^ den[DW-1];
        rem_nxt   = '0;
        dq_nxt    = QW'(num[NW-1] ? NW'(-num) : NW'(num)) << FRAC_BITS;
        cnt_nxt   = CNT_W'(QW);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? DW'(rem_sh - {1'b0, dmag_r}) : rem_sh[DW-1:0];
        dq_nxt  = {dq_r[QW-2:0], rem_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        next_nxt  = (usum[SW-1:31] != {(SW-31){usum[SW-1]}}) ?
                    (usum[SW-1] ? SAT_NEG : SAT_POS) : usum[31:0];
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        est_nxt = next_r;
        if (solved) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          passes_nxt = passes_r - nfpp_pkg::LIMIT_W'(1);
          state_nxt  = ST_INIT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      tol_r       <= nfpp_pkg::TOL_W'(268);
      limit_r     <= nfpp_pkg::LIMIT_W'(1000);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tol_r       <= tol_nxt;
      limit_r     <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    est_r    <= est_nxt;
    next_r   <= next_nxt;
    passes_r <= passes_nxt;
    poly_r   <= poly_nxt;
    deriv_r  <= deriv_nxt;
    step_r   <= step_nxt;
    prod_r   <= prod_nxt;
    nmag_r   <= nmag_nxt;
    dmag_r   <= dmag_nxt;
    neg_r    <= neg_nxt;
    rem_r    <= rem_nxt;
    dq_r     <= dq_nxt;
    cnt_r    <= cnt_nxt;
  end

endmodule

[test/newton_fixed_point_polynomial_unit_tb.sv]
// ---------------------------------------------------------------------------
// newton_fixed_point_polynomial_unit_tb
// Self-checking bench for the fixed-point Newton polynomial solver. A short
// table of register accesses and solve requests runs first, then random
// requests over a series of tolerance / iteration-limit settings. Every
// root is compared with a bit-exact Newton model kept in the bench.
// ---------------------------------------------------------------------------
module newton_fixed_point_polynomial_unit_tb;

  localparam int FRAC    = nfpp_pkg::FRAC_BITS_DEF;
  localparam int DEG     = nfpp_pkg::DEGREE_DEF;
  localparam int TOL_W   = nfpp_pkg::TOL_W;
  localparam int LIMIT_W = nfpp_pkg::LIMIT_W;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam longint unsigned QUOT_LIMIT = 64'd1 << 33;

  localparam logic [2:0] REG_TOLERANCE  = 3'd0;
  localparam logic [2:0] REG_ITER_LIMIT = 3'd4;

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int PASS_CAP        = 32;     // random requests kept to this many passes
  localparam int NO_CAP          = 65537;
  localparam int TAIL_CYCLES     = 300;
  localparam int TIMEOUT         = 100_000_000;

  typedef enum logic [1:0] {ROW_SOLVE, ROW_WRITE, ROW_READ} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  reg_addr;
    logic [31:0] value;
    logic [31:0] want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 27;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_READ,  REG_TOLERANCE,  32'h0000_0000, 32'd268},
    '{ROW_READ,  REG_ITER_LIMIT, 32'h0000_0000, 32'd1000},
    '{ROW_SOLVE, REG_TOLERANCE,  32'h0000_0000, 32'h0},
    '{ROW_SOLVE, REG_TOLERANCE,  32'h1000_0000, 32'h0},
    '{ROW_SOLVE, REG_TOLERANCE,  32'hFFFF_FFFF, 32'h0},
    '{ROW_SOLVE, REG_TOLERANCE,  32'h8000_0000, 32'h0},
    '{ROW_SOLVE, REG_TOLERANCE,  32'h7FFF_FFFF, 32'h0},
    '{ROW_SOLVE, REG_TOLERANCE,  32'h1000_0001, 32'h0},
    '{ROW_WRITE, REG_ITER_LIMIT, 32'h0000_0000, 32'h0},
    '{ROW_WRITE, REG_TOLERANCE,  32'h0000_0000, 32'h0},
    '{ROW_READ,  REG_TOLERANCE,  32'h0000_0000, 32'h0},
    '{ROW_SOLVE, REG_TOLERANCE,  32'h0800_0000, 32'h0},
    '{ROW_SOLVE, REG_TOLERANCE,  32'h0000_0001, 32'h0},
    '{ROW_SOLVE, REG_TOLERANCE,  32'h0FFF_FFFF, 32'h0},
    '{ROW_WRITE, REG_ITER_LIMIT, 32'hABCD_0014, 32'h0},
    '{ROW_READ,  REG_ITER_LIMIT, 32'h0000_0000, 32'h0000_0014},
    '{ROW_SOLVE, REG_TOLERANCE,  32'h0F5C_28F6, 32'h0},
    '{ROW_SOLVE, REG_TOLERANCE,  32'h0C00_0000, 32'h0},
    '{ROW_WRITE, REG_TOLERANCE,  32'hFFFF_FFFF, 32'h0},
    '{ROW_READ,  REG_TOLERANCE,  32'h0000_0000, 32'h1FFF_FFFF},
    '{ROW_WRITE, REG_ITER_LIMIT, 32'h0000_FFFF, 32'h0},
    '{ROW_READ,  REG_ITER_LIMIT, 32'h0000_0000, 32'h0000_FFFF},
    '{ROW_SOLVE, REG_TOLERANCE,  32'h1000_0000, 32'h0},
    '{ROW_SOLVE, REG_TOLERANCE,  32'h0200_0000, 32'h0},
    '{ROW_WRITE, REG_TOLERANCE,  32'h0000_010C, 32'h0},
    '{ROW_WRITE, REG_ITER_LIMIT, 32'h0000_0028, 32'h0},
    '{ROW_SOLVE, REG_TOLERANCE,  32'h0F5C_28F6, 32'h0}
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_start_value;
  logic               out_valid;
  logic signed [31:0] out_root_value;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  logic [TOL_W-1:0]   tol_setting;
  logic [LIMIT_W-1:0] limit_setting;

  logic signed [31:0] expected_roots[$];

  int mismatch_count;
  int requests_sent;
  int roots_checked;
  int saturated_roots;
  int settings_used;
  int skipped_slow;
  int total_passes;

  newton_fixed_point_polynomial_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_start_value (in_start_value),
    .out_valid      (out_valid),
    .out_root_value (out_root_value),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- Newton model -------------------------------------------------------

  function automatic longint clamp32(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // round(k * 2^FRAC / 10000), halves up
  function automatic longint coef_fixed(input int i);
    longint unsigned k;
    case (i)
      0:       k = 64'd4982;
      1:       k = 64'd2103;
      2:       k = 64'd1270;
      3:       k = 64'd730;
      4:       k = 64'd418;
      5:       k = 64'd241;
      6:       k = 64'd132;
      7:       k = 64'd69;
      8:       k = 64'd35;
      9:       k = 64'd15;
      10:      k = 64'd5;
      default: k = 64'd0;
    endcase
    return longint'(((k << FRAC) + 64'd5000) / 64'd10000);
  endfunction

  // product floored (arithmetic shift), sum saturated
  function automatic longint mac_step(input longint x, input longint acc,
                                      input longint term);
    return clamp32(((x * acc) >>> FRAC) + term);
  endfunction

  function automatic longint unsigned divide_mag(input longint unsigned n,
                                                 input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    if (d == 0) return (n == 0) ? 64'd0 : QUOT_LIMIT;
    q = n / d;
    if (q >= QUOT_LIMIT) return QUOT_LIMIT;
    r = n % d;
    for (int b = 0; b < FRAC; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        q = q | 64'd1;
        r = r - d;
      end
      if (q >= QUOT_LIMIT) return QUOT_LIMIT;
    end
    return q;
  endfunction

  // Returns 0 when the solve would need more than pass_cap passes.
  function automatic bit predict_root(input logic signed [31:0] start_val,
                                      input logic [TOL_W-1:0] tol,
                                      input logic [LIMIT_W-1:0] limit,
                                      input int pass_cap,
                                      output logic signed [31:0] root,
                                      output int passes);
    longint s;
    longint pa;
    longint da;
    longint num;
    longint den;
    longint nxt;
    longint diff;
    longint tol_l;
    longint unsigned q;
    int unsigned left;
    bit neg;
    s = longint'(start_val);
    tol_l = longint'(tol);
    if (s < 0 || s > (longint'(1) << FRAC)) s = 0;
    left = 32'(limit);
    passes = 0;
    root = '0;
    forever begin
      if (passes >= pass_cap) return 1'b0;
      pa = coef_fixed(DEG);
      da = 0;
      for (int k = DEG - 1; k >= 0; k--) begin
        da = mac_step(s, da, pa);
        pa = mac_step(s, pa, coef_fixed(k));
      end
      num = pa - s;
      den = (longint'(1) << FRAC) - da;
      q = divide_mag(longint'(num < 0 ? -num : num), longint'(den < 0 ? -den : den));
      neg = (num < 0) != (den < 0);
      nxt = clamp32(neg ? s - longint'(q) : s + longint'(q));
      diff = nxt - s;
      if (diff < 0) diff = -diff;
      s = nxt;
      passes++;
      if (diff <= tol_l || left == 0) break;
      left--;
    end
    root = s[31:0];
    return 1'b1;
  endfunction

  // ---- checking -----------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40)
      $display("mismatch at %0t: %s, got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_roots
    logic signed [31:0] want;
    if (rst_n && out_valid) begin
      if (expected_roots.size() == 0) begin
        report_mismatch("root with no request pending", out_root_value, 32'h0);
      end else begin
        want = expected_roots.pop_front();
        roots_checked++;
        if (want == 32'sh7FFF_FFFF || want == 32'sh8000_0000) saturated_roots++;
        if (out_root_value !== want)
          report_mismatch("root_value", out_root_value, want);
      end
    end
  end

  // ---- stimulus -----------------------------------------------------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(100, 400);
  endfunction

  function automatic logic [31:0] pick_start();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 32'h1000_0000);
    if (r < 80) return $urandom;
    if (r < 90) begin
      case ($urandom_range(0, 7))
        0:       return 32'h0000_0000;
        1:       return 32'h0000_0001;
        2:       return 32'h0FFF_FFFF;
        3:       return 32'h1000_0000;
        4:       return 32'h1000_0001;
        5:       return 32'h8000_0000;
        6:       return 32'hFFFF_FFFF;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    // around the point where P'(s) reaches one: small divisors, big steps
    return $urandom_range(32'h0E00_0000, 32'h1000_0000);
  endfunction

  task automatic send_request(input logic signed [31:0] value,
                              input logic signed [31:0] root);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_start_value <= value;
    do @(posedge clk); while (busy);
    expected_roots.push_back(root);
    requests_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // bus goes idle between accesses
    @(posedge clk);
    if (write) begin
      if (addr == REG_TOLERANCE) tol_setting = data[TOL_W-1:0];
      else if (addr == REG_ITER_LIMIT) limit_setting = data[LIMIT_W-1:0];
      settings_used++;
    end
  endtask

  task automatic check_readback();
    logic [31:0] rd;
    cfg_access(1'b0, REG_TOLERANCE, 32'h0, rd);
    if (rd !== 32'(tol_setting)) report_mismatch("tolerance readback", rd, 32'(tol_setting));
    cfg_access(1'b0, REG_ITER_LIMIT, 32'h0, rd);
    if (rd !== 32'(limit_setting))
      report_mismatch("iteration_limit readback", rd, 32'(limit_setting));
  endtask

  task automatic apply_phase_settings(input int phase);
    logic [TOL_W-1:0]   tol;
    logic [LIMIT_W-1:0] limit;
    logic [31:0]        noise;
    logic [31:0]        rd;
    noise = $urandom;
    case (phase)
      0: begin tol = '0;               limit = '0;        end
      1: begin tol = '1;               limit = '1;        end
      2: begin tol = 29'h1000_0000;    limit = 16'd1000;  end
      3: begin tol = 29'd268;          limit = '1;        end
      default: begin
        case ($urandom_range(0, 3))
          0:       tol = TOL_W'($urandom_range(0, 64));
          1:       tol = TOL_W'($urandom_range(0, 4000));
          2:       tol = TOL_W'($urandom);
          default: tol = 29'd268;
        endcase
        case ($urandom_range(0, 2))
          0:       limit = LIMIT_W'($urandom_range(0, 8));
          1:       limit = LIMIT_W'($urandom_range(9, 64));
          default: limit = LIMIT_W'($urandom);
        endcase
      end
    endcase
    // bits above each field carry junk that the block must drop
    cfg_access(1'b1, REG_TOLERANCE, {noise[31:TOL_W], tol}, rd);
    cfg_access(1'b1, REG_ITER_LIMIT, {noise[31:LIMIT_W], limit}, rd);
    check_readback();
  endtask

  initial begin
    #TIMEOUT;
    $display("timeout with %0d roots outstanding", expected_roots.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : run
    logic signed [31:0] root;
    logic [31:0]        value;
    logic [31:0]        rd;
    int                 passes;
    bit                 fits;

    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_start_value <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    tol_setting    = 29'd268;
    limit_setting  = 16'd1000;
    mismatch_count = 0;
    requests_sent  = 0;
    roots_checked  = 0;
    saturated_roots = 0;
    settings_used  = 0;
    skipped_slow   = 0;
    total_passes   = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      case (DIRECTED[i].kind)
        ROW_SOLVE: begin
          fits = predict_root(DIRECTED[i].value, tol_setting, limit_setting, NO_CAP,
                              root, passes);
          total_passes += passes;
          send_request(DIRECTED[i].value, root);
        end
        ROW_WRITE: begin
          wait_idle();
          cfg_access(1'b1, DIRECTED[i].reg_addr, DIRECTED[i].value, rd);
        end
        default: begin
          wait_idle();
          cfg_access(1'b0, DIRECTED[i].reg_addr, 32'h0, rd);
          if (rd !== DIRECTED[i].want)
            report_mismatch("register read", rd, DIRECTED[i].want);
        end
      endcase
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      apply_phase_settings(phase);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // redraw starts that would run past the pass budget
        fits = 1'b0;
        for (int t = 0; t < 8 && !fits; t++) begin
          value = pick_start();
          fits = predict_root(value, tol_setting, limit_setting, PASS_CAP, root, passes);
        end
        if (fits) begin
          total_passes += passes;
          send_request(value, root);
        end else begin
          skipped_slow++;
        end
        if ($urandom_range(0, 39) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d solve requests (%0d Newton passes) over %0d register writes, %0d roots compared",
             requests_sent, total_passes, settings_used, roots_checked);
    $display("%0d roots at a saturation limit, %0d starts passed over as too slow",
             saturated_roots, skipped_slow);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/nfpp_pkg.sv
design/newton_fixed_point_polynomial_unit.sv
test/newton_fixed_point_polynomial_unit_tb.sv
